@@ rtl/stuck_at_fault_table_unit_defines.svh @@
// Assertion macros for the stuck-at fault table unit.
// Included by the top level; needs signals clock and reset in scope.
`ifndef STUCK_AT_FAULT_TABLE_UNIT_DEFINES_SVH
`define STUCK_AT_FAULT_TABLE_UNIT_DEFINES_SVH

// Same-cycle implication, disabled during reset.
`define SAFT_ASSERT_NOW(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication, disabled during reset.
`define SAFT_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

@@ rtl/saft_pkg.sv @@
// Shared types and constants for the stuck-at fault table unit.
// No dependencies; used by every module of the block.
package saft_pkg;

   localparam int SAFT_TABLE_DEPTH = 16;
   localparam int SAFT_ADDR_BITS   = 40;
   localparam int DATA_BITS        = 8;
   localparam int FUNC_W           = 2;
   localparam int STATUS_W         = 2;
   localparam int BITCNT_W         = 4;
   localparam int MAX_BIT_COUNT    = 8;

   typedef enum logic [FUNC_W-1:0] {
      FUNC_READ   = 2'd0,
      FUNC_INSERT = 2'd1,
      FUNC_DELETE = 2'd2,
      FUNC_CLEAR  = 2'd3
   } func_type;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK        = 2'd0,
      ST_INVALID   = 2'd1,
      ST_FULL      = 2'd2,
      ST_NOT_FOUND = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      OP_NONE,
      OP_NEW,
      OP_UPDATE,
      OP_DELETE,
      OP_CLEAR
   } tbl_op_type;

   // Lookup flags from the table to the executor.
   typedef struct packed {
      logic hit;
      logic free_avail;
   } lookup_type;

   // Table change requested by the executor.
   typedef struct packed {
      tbl_op_type op;
   } update_type;

endpackage

@@ rtl/saft_table.sv @@
// Fault table storage: valid bits, keys, masks, stuck values and entry count.
// Parallel key compare and first-free search. Depends on saft_pkg.
module saft_table import saft_pkg::*; #(
   parameter int TABLE_DEPTH = SAFT_TABLE_DEPTH,
   parameter int ADDR_BITS   = SAFT_ADDR_BITS,
   parameter int IDX_W       = 4,
   parameter int CNT_W       = 5
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic [ADDR_BITS-1:0] lk_addr,
   output lookup_type           lk,
   output logic [IDX_W-1:0]     hit_idx,
   output logic [IDX_W-1:0]     free_idx,
   output logic [DATA_BITS-1:0] rd_mask,
   output logic [DATA_BITS-1:0] rd_vals,
   output logic [CNT_W-1:0]     count,
   input  update_type           upd,
   input  logic [IDX_W-1:0]     wr_idx,
   input  logic [ADDR_BITS-1:0] wr_addr,
   input  logic [DATA_BITS-1:0] wr_mask,
   input  logic [DATA_BITS-1:0] wr_vals,
   input  logic [CNT_W-1:0]     cnt_in
);

   logic [TABLE_DEPTH-1:0] valid_ff;
   logic [ADDR_BITS-1:0]   addr_ff [TABLE_DEPTH];
   logic [DATA_BITS-1:0]   mask_ff [TABLE_DEPTH];
   logic [DATA_BITS-1:0]   vals_ff [TABLE_DEPTH];
   logic [CNT_W-1:0]       count_ff;
   logic [TABLE_DEPTH-1:0] match;

   always_comb begin
      for (int i = 0; i < TABLE_DEPTH; i++) begin
         match[i] = valid_ff[i] && (addr_ff[i] == lk_addr);
      end
   end

   // Lowest index wins for both the match and the free slot.
   always_comb begin
      lk       = '0;
      hit_idx  = '0;
      free_idx = '0;
      for (int i = TABLE_DEPTH - 1; i >= 0; i--) begin
         if (match[i]) begin
            lk.hit  = 1'b1;
            hit_idx = IDX_W'(i);
         end
         if (!valid_ff[i]) begin
            lk.free_avail = 1'b1;
            free_idx      = IDX_W'(i);
         end
      end
   end

   assign rd_mask = mask_ff[hit_idx];
   assign rd_vals = vals_ff[hit_idx];
   assign count   = count_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= '0;
         count_ff <= '0;
      end else begin
         case (upd.op)
            OP_NEW:    valid_ff[wr_idx] <= 1'b1;
            OP_DELETE: valid_ff[wr_idx] <= 1'b0;
            OP_CLEAR:  valid_ff <= '0;
            default:   ;
         endcase
         if (upd.op != OP_NONE) begin
            count_ff <= cnt_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (upd.op == OP_NEW) begin
         addr_ff[wr_idx] <= wr_addr;
      end
      if (upd.op == OP_NEW || upd.op == OP_UPDATE) begin
         mask_ff[wr_idx] <= wr_mask;
         vals_ff[wr_idx] <= wr_vals;
      end
   end

endmodule

@@ rtl/saft_exec.sv @@
// Operation decode: builds the result word and the table change for one item.
// Purely combinational; depends on saft_pkg.
module saft_exec import saft_pkg::*; #(
   parameter int IDX_W = 4,
   parameter int CNT_W = 5
) (
   input  logic [FUNC_W-1:0]    func,
   input  logic [DATA_BITS-1:0] data_in,
   input  logic [BITCNT_W-1:0]  error_bit_count,
   input  lookup_type           lk,
   input  logic [IDX_W-1:0]     hit_idx,
   input  logic [IDX_W-1:0]     free_idx,
   input  logic [DATA_BITS-1:0] rd_mask,
   input  logic [DATA_BITS-1:0] rd_vals,
   input  logic [CNT_W-1:0]     count,
   output logic [DATA_BITS-1:0] data_out,
   output logic                 hit,
   output status_type           status,
   output logic [CNT_W-1:0]     cnt_next,
   output update_type           upd,
   output logic [IDX_W-1:0]     wr_idx
);

   always_comb begin
      data_out = '0;
      hit      = lk.hit;
      status   = ST_OK;
      cnt_next = count;
      upd.op   = OP_NONE;
      wr_idx   = hit_idx;
      case (func_type'(func))
         FUNC_READ: begin
            data_out = lk.hit ? ((data_in & ~rd_mask) | (rd_vals & rd_mask)) : data_in;
         end
         FUNC_INSERT: begin
            // Bit count check comes before the full check.
            if (error_bit_count > BITCNT_W'(MAX_BIT_COUNT)) begin
               status = ST_INVALID;
            end else if (lk.hit) begin
               upd.op = OP_UPDATE;
            end else if (lk.free_avail) begin
               upd.op   = OP_NEW;
               wr_idx   = free_idx;
               cnt_next = count + CNT_W'(1);
            end else begin
               status = ST_FULL;
            end
         end
         FUNC_DELETE: begin
            if (lk.hit) begin
               upd.op   = OP_DELETE;
               cnt_next = count - CNT_W'(1);
            end else begin
               status = ST_NOT_FOUND;
            end
         end
         FUNC_CLEAR: begin
            hit      = 1'b0;
            upd.op   = OP_CLEAR;
            cnt_next = '0;
         end
         default: ;
      endcase
   end

endmodule

@@ rtl/stuck_at_fault_table_unit.sv @@
// Stuck-at fault table unit: holds up to TABLE_DEPTH fault entries keyed by byte
// address and applies their stuck bits to bytes read through it. Every word on
// req_ gives exactly one word on rsp_. A word accepted on req_ lands in the input
// register, and its result word is offered on rsp_ once it has moved from there into
// the result register. The unit takes one item per cycle while rsp_ready is high;
// a result word held by rsp_ready low holds the input register, and req_ready stays
// low while that register is full and cannot advance. The rate is set by the
// combinational parallel compare over the flip-flop table, which is also updated
// as the item moves on into the result register, so the next item sees it.
// Depends on saft_pkg, saft_table, saft_exec and the assertion macro header.
module stuck_at_fault_table_unit import saft_pkg::*; #(
   parameter int TABLE_DEPTH = SAFT_TABLE_DEPTH,
   parameter int ADDR_BITS   = SAFT_ADDR_BITS
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [FUNC_W-1:0]                  req_func,
   input  logic [ADDR_BITS-1:0]               req_address,
   input  logic [DATA_BITS-1:0]               req_data_in,
   input  logic [DATA_BITS-1:0]               req_stuck_mask,
   input  logic [DATA_BITS-1:0]               req_stuck_values,
   input  logic [BITCNT_W-1:0]                req_error_bit_count,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [DATA_BITS-1:0]               rsp_data_out,
   output logic                               rsp_hit,
   output logic [STATUS_W-1:0]                rsp_status,
   output logic [$clog2(TABLE_DEPTH+1)-1:0]   rsp_entry_count
);

   localparam int IDX_W = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam int CNT_W = $clog2(TABLE_DEPTH + 1);

   // Input register
   logic                 s1_valid_ff, s1_valid_in;
   logic [FUNC_W-1:0]    s1_func_ff;
   logic [ADDR_BITS-1:0] s1_addr_ff;
   logic [DATA_BITS-1:0] s1_din_ff;
   logic [DATA_BITS-1:0] s1_mask_ff;
   logic [DATA_BITS-1:0] s1_vals_ff;
   logic [BITCNT_W-1:0]  s1_nbits_ff;

   // Result register
   logic                 rsp_valid_ff, rsp_valid_in;
   logic [DATA_BITS-1:0] rsp_data_ff;
   logic                 rsp_hit_ff;
   logic [STATUS_W-1:0]  rsp_status_ff;
   logic [CNT_W-1:0]     rsp_count_ff;

   logic                 rsp_free;
   logic                 s1_go;
   logic                 req_take;

   lookup_type           lk;
   logic [IDX_W-1:0]     hit_idx;
   logic [IDX_W-1:0]     free_idx;
   logic [DATA_BITS-1:0] rd_mask;
   logic [DATA_BITS-1:0] rd_vals;
   logic [CNT_W-1:0]     count;

   logic [DATA_BITS-1:0] ex_data;
   logic                 ex_hit;
   status_type           ex_status;
   logic [CNT_W-1:0]     ex_count;
   update_type           ex_upd;
   update_type           upd;
   logic [IDX_W-1:0]     wr_idx;

   assign rsp_free  = !rsp_valid_ff || rsp_ready;
   assign s1_go     = s1_valid_ff && rsp_free;
   assign req_ready = !s1_valid_ff || s1_go;
   assign req_take  = req_valid && req_ready;

   assign s1_valid_in  = req_take || (s1_valid_ff && !s1_go);
   assign rsp_valid_in = s1_go || (rsp_valid_ff && !rsp_ready);

   // Commit table changes only when the item moves into the result register.
   always_comb begin
      upd = ex_upd;
      if (!s1_go) begin
         upd.op = OP_NONE;
      end
   end

   saft_table #(
      .TABLE_DEPTH (TABLE_DEPTH),
      .ADDR_BITS   (ADDR_BITS),
      .IDX_W       (IDX_W),
      .CNT_W       (CNT_W)
   ) u_table (
      .clock    (clock),
      .reset    (reset),
      .lk_addr  (s1_addr_ff),
      .lk       (lk),
      .hit_idx  (hit_idx),
      .free_idx (free_idx),
      .rd_mask  (rd_mask),
      .rd_vals  (rd_vals),
      .count    (count),
      .upd      (upd),
      .wr_idx   (wr_idx),
      .wr_addr  (s1_addr_ff),
      .wr_mask  (s1_mask_ff),
      .wr_vals  (s1_vals_ff),
      .cnt_in   (ex_count)
   );

   saft_exec #(
      .IDX_W (IDX_W),
      .CNT_W (CNT_W)
   ) u_exec (
      .func            (s1_func_ff),
      .data_in         (s1_din_ff),
      .error_bit_count (s1_nbits_ff),
      .lk              (lk),
      .hit_idx         (hit_idx),
      .free_idx        (free_idx),
      .rd_mask         (rd_mask),
      .rd_vals         (rd_vals),
      .count           (count),
      .data_out        (ex_data),
      .hit             (ex_hit),
      .status          (ex_status),
      .cnt_next        (ex_count),
      .upd             (ex_upd),
      .wr_idx          (wr_idx)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         s1_valid_ff  <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         s1_valid_ff  <= s1_valid_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (req_take) begin
         s1_func_ff  <= req_func;
         s1_addr_ff  <= req_address;
         s1_din_ff   <= req_data_in;
         s1_mask_ff  <= req_stuck_mask;
         s1_vals_ff  <= req_stuck_values;
         s1_nbits_ff <= req_error_bit_count;
      end
      if (s1_go) begin
         rsp_data_ff   <= ex_data;
         rsp_hit_ff    <= ex_hit;
         rsp_status_ff <= ex_status;
         rsp_count_ff  <= ex_count;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_data_out    = rsp_data_ff;
   assign rsp_hit         = rsp_hit_ff;
   assign rsp_status      = rsp_status_ff;
   assign rsp_entry_count = rsp_count_ff;

`include "stuck_at_fault_table_unit_defines.svh"

   `SAFT_ASSERT_NOW(a_full_at_depth, rsp_valid && rsp_status == ST_FULL, rsp_entry_count == CNT_W'(TABLE_DEPTH), "table full reported below depth")
   `SAFT_ASSERT_NOW(a_not_found_no_hit, rsp_valid && rsp_status == ST_NOT_FOUND, !rsp_hit, "not found reported with hit")
   `SAFT_ASSERT_NEXT(a_clear_empties, s1_go && s1_func_ff == FUNC_CLEAR, count == '0, "entry count not zero after clear")
   `SAFT_ASSERT_NEXT(a_new_counts_up, upd.op == OP_NEW, count == $past(count) + CNT_W'(1), "new entry did not raise count")

endmodule

@@ sim/tb_stuck_at_fault_table_unit.sv @@
// Testbench for stuck_at_fault_table_unit: directed and random fault-table traffic
// with a shadow table predicting every response word, checked in order.
// Depends on saft_pkg and the unit RTL.
module tb_stuck_at_fault_table_unit import saft_pkg::*;;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int ENTRY_W        = $clog2(SAFT_TABLE_DEPTH + 1);
   localparam int POOL_SIZE      = 24;
   localparam int WATCHDOG_LIMIT = 1000;

   typedef logic [SAFT_ADDR_BITS-1:0] addr_type;

   typedef struct packed {
      func_type              func;
      addr_type              address;
      logic [DATA_BITS-1:0]  data_in;
      logic [DATA_BITS-1:0]  stuck_mask;
      logic [DATA_BITS-1:0]  stuck_values;
      logic [BITCNT_W-1:0]   bit_count;
   } fault_op_type;

   typedef struct packed {
      logic [DATA_BITS-1:0]  data_out;
      logic                  hit;
      status_type            status;
      logic [ENTRY_W-1:0]    entry_count;
   } fault_rsp_type;

   logic                  clock;
   logic                  reset;
   logic                  req_valid;
   logic                  req_ready;
   logic [FUNC_W-1:0]     req_func;
   addr_type              req_address;
   logic [DATA_BITS-1:0]  req_data_in;
   logic [DATA_BITS-1:0]  req_stuck_mask;
   logic [DATA_BITS-1:0]  req_stuck_values;
   logic [BITCNT_W-1:0]   req_error_bit_count;
   logic                  rsp_valid;
   logic                  rsp_ready = 1'b0;
   logic [DATA_BITS-1:0]  rsp_data_out;
   logic                  rsp_hit;
   logic [STATUS_W-1:0]   rsp_status;
   logic [ENTRY_W-1:0]    rsp_entry_count;

   // Shadow of the fault table
   logic                  shadow_valid [SAFT_TABLE_DEPTH];
   addr_type              shadow_addr  [SAFT_TABLE_DEPTH];
   logic [DATA_BITS-1:0]  shadow_mask  [SAFT_TABLE_DEPTH];
   logic [DATA_BITS-1:0]  shadow_vals  [SAFT_TABLE_DEPTH];
   int                    shadow_count = 0;

   fault_rsp_type         fault_rsp_q [$];
   addr_type              addr_pool [POOL_SIZE];
   int                    fail_count = 0;
   int                    quiet_cycles = 0;
   int                    stall_left = 0;
   bit                    send_idle_en = 1'b1;
   bit                    rsp_idle_en = 1'b1;
   fault_rsp_type         seen_rsp;
   fault_rsp_type         want_rsp;
   fault_op_type          seen_op;

   stuck_at_fault_table_unit dut (
      .clock               (clock),
      .reset               (reset),
      .req_valid           (req_valid),
      .req_ready           (req_ready),
      .req_func            (req_func),
      .req_address         (req_address),
      .req_data_in         (req_data_in),
      .req_stuck_mask      (req_stuck_mask),
      .req_stuck_values    (req_stuck_values),
      .req_error_bit_count (req_error_bit_count),
      .rsp_valid           (rsp_valid),
      .rsp_ready           (rsp_ready),
      .rsp_data_out        (rsp_data_out),
      .rsp_hit             (rsp_hit),
      .rsp_status          (rsp_status),
      .rsp_entry_count     (rsp_entry_count)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   initial begin
      for (int i = 0; i < SAFT_TABLE_DEPTH; i++) begin
         shadow_valid[i] = 1'b0;
      end
   end

   // Apply one operation to the shadow table and return the response it gives.
   function automatic fault_rsp_type apply_fault_op(fault_op_type op);
      fault_rsp_type r;
      int            idx;
      int            slot;
      r = '0;
      r.status = ST_OK;
      idx = -1;
      slot = -1;
      for (int i = SAFT_TABLE_DEPTH - 1; i >= 0; i--) begin
         if (shadow_valid[i] && shadow_addr[i] == op.address) idx = i;
         if (!shadow_valid[i]) slot = i;
      end
      case (op.func)
         FUNC_READ: begin
            if (idx >= 0) begin
               r.hit = 1'b1;
               r.data_out = (op.data_in & ~shadow_mask[idx]) |
                            (shadow_vals[idx] & shadow_mask[idx]);
            end else begin
               r.data_out = op.data_in;
            end
         end
         FUNC_INSERT: begin
            r.hit = (idx >= 0);
            if (op.bit_count > MAX_BIT_COUNT) begin
               r.status = ST_INVALID;
            end else if (idx < 0 && slot < 0) begin
               r.status = ST_FULL;
            end else begin
               if (idx < 0) begin
                  idx = slot;
                  shadow_valid[idx] = 1'b1;
                  shadow_addr[idx] = op.address;
                  shadow_count++;
               end
               shadow_mask[idx] = op.stuck_mask;
               shadow_vals[idx] = op.stuck_values;
            end
         end
         FUNC_DELETE: begin
            if (idx >= 0) begin
               r.hit = 1'b1;
               shadow_valid[idx] = 1'b0;
               shadow_count--;
            end else begin
               r.status = ST_NOT_FOUND;
            end
         end
         default: begin
            for (int i = 0; i < SAFT_TABLE_DEPTH; i++) shadow_valid[i] = 1'b0;
            shadow_count = 0;
         end
      endcase
      r.entry_count = shadow_count[ENTRY_W-1:0];
      return r;
   endfunction

   // Check each response word, then predict each accepted request word.
   always @(posedge clock) begin
      if (!reset) begin
         if (rsp_valid === 1'b1 && rsp_ready) begin
            seen_rsp.data_out = rsp_data_out;
            seen_rsp.hit = rsp_hit;
            seen_rsp.status = status_type'(rsp_status);
            seen_rsp.entry_count = rsp_entry_count;
            if (fault_rsp_q.size() == 0) begin
               fail_count++;
               if (fail_count <= 10) $display("%0t: response word with none expected", $realtime);
            end else begin
               want_rsp = fault_rsp_q.pop_front();
               if (seen_rsp.data_out !== want_rsp.data_out || seen_rsp.hit !== want_rsp.hit ||
                   seen_rsp.status !== want_rsp.status ||
                   seen_rsp.entry_count !== want_rsp.entry_count) begin
                  fail_count++;
                  if (fail_count <= 10)
                     $display("%0t: data_out %h/%h hit %b/%b status %0d/%0d count %0d/%0d (exp/got)",
                              $realtime, want_rsp.data_out, seen_rsp.data_out,
                              want_rsp.hit, seen_rsp.hit, want_rsp.status, seen_rsp.status,
                              want_rsp.entry_count, seen_rsp.entry_count);
               end
            end
         end
         if (req_valid && req_ready === 1'b1) begin
            seen_op.func = func_type'(req_func);
            seen_op.address = req_address;
            seen_op.data_in = req_data_in;
            seen_op.stuck_mask = req_stuck_mask;
            seen_op.stuck_values = req_stuck_values;
            seen_op.bit_count = req_error_bit_count;
            fault_rsp_q.push_back(apply_fault_op(seen_op));
         end
      end
   end

   // Response-side backpressure in random bursts
   always @(posedge clock) begin
      if (stall_left > 0) begin
         stall_left <= stall_left - 1;
         rsp_ready <= 1'b0;
      end else if (rsp_idle_en && $urandom_range(0, 5) == 0) begin
         stall_left <= $urandom_range(0, 9);
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (reset || (req_valid && req_ready) || (rsp_valid && rsp_ready)) begin
         quiet_cycles <= 0;
      end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
         $display("Test completed with failures");
         $finish;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
      end
   end

   task automatic send_word(input fault_op_type op);
      if (send_idle_en && $urandom_range(0, 3) == 0) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 10)) @(posedge clock);
      end
      req_func <= op.func;
      req_address <= op.address;
      req_data_in <= op.data_in;
      req_stuck_mask <= op.stuck_mask;
      req_stuck_values <= op.stuck_values;
      req_error_bit_count <= op.bit_count;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_ready !== 1'b1);
   endtask

   // Hold the sender until every expected response word has come back.
   task automatic wait_drained();
      req_valid <= 1'b0;
      @(posedge clock);
      while (fault_rsp_q.size() != 0) @(posedge clock);
   endtask

   function automatic fault_op_type mk_op(func_type func, addr_type address,
                                          logic [7:0] din, logic [7:0] mask,
                                          logic [7:0] vals, logic [3:0] cnt);
      fault_op_type op;
      op.func = func;
      op.address = address;
      op.data_in = din;
      op.stuck_mask = mask;
      op.stuck_values = vals;
      op.bit_count = cnt;
      return op;
   endfunction

   // Mostly table addresses, some one-bit neighbors and some fresh ones.
   function automatic addr_type pick_address();
      addr_type a;
      int       roll;
      roll = $urandom_range(0, 99);
      a = addr_pool[$urandom_range(0, POOL_SIZE - 1)];
      if (roll < 15) a = a ^ (addr_type'(1) << $urandom_range(0, SAFT_ADDR_BITS - 1));
      else if (roll < 30) a = addr_type'({$urandom, $urandom});
      return a;
   endfunction

   function automatic fault_op_type make_random_op(bit fill);
      fault_op_type op;
      int           roll;
      roll = $urandom_range(0, 99);
      if (roll < (fill ? 35 : 45)) op.func = FUNC_READ;
      else if (roll < (fill ? 90 : 80)) op.func = FUNC_INSERT;
      else if (roll < 98) op.func = FUNC_DELETE;
      else op.func = FUNC_CLEAR;
      op.address = pick_address();
      op.data_in = DATA_BITS'($urandom);
      op.stuck_mask = DATA_BITS'($urandom);
      op.stuck_values = DATA_BITS'($urandom);
      op.bit_count = ($urandom_range(0, 4) == 0) ? BITCNT_W'($urandom_range(9, 15))
                                                 : BITCNT_W'($urandom_range(0, 8));
      return op;
   endfunction

   task automatic test_empty_table();
      send_word(mk_op(FUNC_READ, '0, 8'hff, 8'h00, 8'h00, 4'd0));
      send_word(mk_op(FUNC_READ, '1, 8'h00, 8'hff, 8'hff, 4'd15));
      send_word(mk_op(FUNC_DELETE, '0, 8'h00, 8'h00, 8'h00, 4'd0));
      send_word(mk_op(FUNC_CLEAR, '1, 8'hff, 8'hff, 8'hff, 4'd15));
      send_word(mk_op(FUNC_INSERT, 40'h12_3456_789a, 8'h00, 8'hff, 8'hff, 4'd9));
      send_word(mk_op(FUNC_INSERT, 40'h12_3456_789a, 8'h00, 8'h01, 8'h01, 4'd15));
   endtask

   task automatic test_update_and_delete();
      send_word(mk_op(FUNC_INSERT, '0, 8'h00, 8'hff, 8'h00, 4'd8));
      send_word(mk_op(FUNC_INSERT, '1, 8'h00, 8'h0f, 8'ha5, 4'd4));
      send_word(mk_op(FUNC_READ, '0, 8'hff, 8'h00, 8'h00, 4'd0));
      send_word(mk_op(FUNC_READ, '1, 8'h00, 8'h00, 8'h00, 4'd0));
      // rejected update must leave the old entry in place
      send_word(mk_op(FUNC_INSERT, '1, 8'h00, 8'hff, 8'hff, 4'd12));
      send_word(mk_op(FUNC_INSERT, '0, 8'h00, 8'haa, 8'hff, 4'd0));
      send_word(mk_op(FUNC_READ, '0, 8'h00, 8'h00, 8'h00, 4'd0));
      send_word(mk_op(FUNC_READ, '1, 8'hf0, 8'h00, 8'h00, 4'd0));
      send_word(mk_op(FUNC_READ, 40'h1, 8'h3c, 8'h00, 8'h00, 4'd0));
      send_word(mk_op(FUNC_DELETE, '1, 8'h00, 8'h00, 8'h00, 4'd0));
      send_word(mk_op(FUNC_READ, '1, 8'hff, 8'h00, 8'h00, 4'd0));
      send_word(mk_op(FUNC_DELETE, '1, 8'h00, 8'h00, 8'h00, 4'd0));
      send_word(mk_op(FUNC_INSERT, '1, 8'h00, 8'h80, 8'h80, 4'd1));
      send_word(mk_op(FUNC_READ, '1, 8'h00, 8'h00, 8'h00, 4'd0));
      send_word(mk_op(FUNC_CLEAR, '0, 8'h00, 8'h00, 8'h00, 4'd0));
      send_word(mk_op(FUNC_READ, '0, 8'h55, 8'h00, 8'h00, 4'd0));
   endtask

   task automatic test_table_full();
      send_word(mk_op(FUNC_CLEAR, '0, 8'h00, 8'h00, 8'h00, 4'd0));
      for (int i = 0; i < SAFT_TABLE_DEPTH; i++)
         send_word(mk_op(FUNC_INSERT, addr_pool[i], 8'h00, 8'($urandom), 8'($urandom),
                         4'($urandom_range(0, 8))));
      send_word(mk_op(FUNC_INSERT, addr_pool[16], 8'h00, 8'hff, 8'h00, 4'd1));
      // bit count check wins over the full check
      send_word(mk_op(FUNC_INSERT, addr_pool[17], 8'h00, 8'hff, 8'h00, 4'd9));
      send_word(mk_op(FUNC_INSERT, addr_pool[3], 8'h00, 8'h3c, 8'h24, 4'd4));
      send_word(mk_op(FUNC_READ, addr_pool[3], 8'($urandom), 8'h00, 8'h00, 4'd0));
      send_word(mk_op(FUNC_DELETE, addr_pool[5], 8'h00, 8'h00, 8'h00, 4'd0));
      send_word(mk_op(FUNC_INSERT, addr_pool[16], 8'h00, 8'hf0, 8'h50, 4'd4));
      send_word(mk_op(FUNC_READ, addr_pool[16], 8'($urandom), 8'h00, 8'h00, 4'd0));
      send_word(mk_op(FUNC_INSERT, addr_pool[17], 8'h00, 8'hff, 8'h00, 4'd8));
      send_word(mk_op(FUNC_CLEAR, '0, 8'h00, 8'h00, 8'h00, 4'd0));
   endtask

   task automatic test_random_mix(input int count);
      bit fill;
      for (int k = 0; k < count; k++) begin
         if (k % 150 == 0) begin
            send_idle_en = ($urandom_range(0, 3) != 0);
            rsp_idle_en = ($urandom_range(0, 3) != 0);
            fill = 1'($urandom_range(0, 1));
         end
         send_word(make_random_op(fill));
      end
   endtask

   task automatic test_back_to_back(input int count);
      send_idle_en = 1'b0;
      rsp_idle_en = 1'b0;
      for (int k = 0; k < count; k++) send_word(make_random_op(k % 100 < 50));
   endtask

   initial begin
      reset = 1'b1;
      req_valid = 1'b0;
      req_func = FUNC_READ;
      req_address = '0;
      req_data_in = '0;
      req_stuck_mask = '0;
      req_stuck_values = '0;
      req_error_bit_count = '0;
      addr_pool[0] = '0;
      addr_pool[1] = '1;
      for (int i = 2; i < POOL_SIZE; i++) addr_pool[i] = addr_type'({$urandom, $urandom});
      repeat (6) @(posedge clock);
      reset <= 1'b0;

      test_empty_table();
      test_update_and_delete();
      test_table_full();
      wait_drained();
      test_random_mix(1200);
      wait_drained();
      test_back_to_back(400);

      wait_drained();
      repeat (20) @(posedge clock);
      if (fail_count == 0) begin
         $display("Test completed successfully");
      end else begin
         $display("Test completed with failures");
      end
      $finish;
   end

endmodule

@@ sim.f @@
+incdir+rtl
rtl/saft_pkg.sv
rtl/saft_table.sv
rtl/saft_exec.sv
rtl/stuck_at_fault_table_unit.sv
sim/tb_stuck_at_fault_table_unit.sv
